/* hw/rtl/bsra_pkg.sv */
// ============================================================================
// bsra_pkg: shared types and constants of the safe resource allocator
// Field widths, register indexes, result codes and the controller/datapath
// command and status bundles.
// ============================================================================
package bsra_pkg;

    // fixed port geometry
    localparam int AMT_BITS     = 8;
    localparam int MAX_RES      = 4;
    localparam int CUST_BITS    = 3;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_REGS     = 6;
    localparam int CLAIM_REGS   = 5;

    // register indexes
    localparam int CFG_TOTAL  = 0;
    localparam int CFG_CLAIM0 = 1;

    // parameter defaults
    localparam int CUSTOMERS_DEF  = 5;
    localparam int RESOURCES_DEF  = 4;
    localparam int COUNT_BITS_DEF = 8;

    // result codes
    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_EXCEEDS   = 3'd1,
        ST_INSUFF    = 3'd2,
        ST_UNSAFE    = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_REL_BIG   = 3'd5
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;      // capture input word
        logic    apply;     // apply release or tentative grant
        logic    step;      // one safety round
        logic    undo;      // roll back tentative grant
        logic    res_load;  // load output word
        status_t res_code;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    is_release;
        logic    chk_pass;
        status_t chk_code;
        logic    pick_found;
        logic    all_done_next;
    } dp_stat_t;

endpackage

/* hw/rtl/bsra_ctrl.sv */
// ============================================================================
// bsra_ctrl: sequencing state machine
// Accepts one input word, runs the checks and the safety rounds through the
// datapath, then hands the result to the output register.
// ============================================================================
module bsra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bsra_pkg::dp_stat_t  stat,
    output bsra_pkg::ctrl_cmd_t cmd
);
    import bsra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_SAFE   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        cmd            = '0;
        cmd.res_code   = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.chk_pass)
                begin
                    res_next   = stat.chk_code;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    if (stat.is_release)
                    begin
                        res_next   = ST_RELEASED;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SAFE;
                    end
                end
            end
            S_SAFE:
            begin
                if (!stat.pick_found)
                begin
                    cmd.undo   = 1'b1;
                    res_next   = ST_UNSAFE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.all_done_next)
                    begin
                        res_next   = ST_GRANTED;
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                // output slot free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= ST_GRANTED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/bsra_datapath.sv */
// ============================================================================
// bsra_datapath: allocation table, checks and safety datapath
// Holds the registers, the allocation table and running allocation sums,
// evaluates need/available checks and one safety round per cycle.
// ============================================================================
module bsra_datapath #(
    parameter int CUSTOMERS  = bsra_pkg::CUSTOMERS_DEF,
    parameter int RESOURCES  = bsra_pkg::RESOURCES_DEF,
    parameter int COUNT_BITS = bsra_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bsra_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bsra_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_op,
    input  logic [bsra_pkg::CUST_BITS-1:0]        in_customer,
    input  logic [bsra_pkg::AMT_BITS-1:0]         in_amount [bsra_pkg::MAX_RES],
    input  bsra_pkg::ctrl_cmd_t                   cmd,
    output bsra_pkg::dp_stat_t                    stat,
    output bsra_pkg::status_t                     out_status,
    output logic [bsra_pkg::AMT_BITS-1:0]         out_avail [bsra_pkg::MAX_RES]
);
    import bsra_pkg::*;

    // field bits taken from a register byte, compare/sum width
    localparam int FW = (COUNT_BITS < AMT_BITS) ? COUNT_BITS : AMT_BITS;
    localparam int CW = ((COUNT_BITS > AMT_BITS) ? COUNT_BITS : AMT_BITS) + 3;

    logic [CFG_W-1:0]      cfg_reg   [CFG_REGS];
    logic [COUNT_BITS-1:0] alloc_reg [CUSTOMERS][RESOURCES];
    logic [CW-1:0]         sum_reg   [RESOURCES];

    logic                  op_reg;
    logic [CUST_BITS-1:0]  cust_reg;
    logic [AMT_BITS-1:0]   amt_reg   [RESOURCES];
    logic [CW-1:0]         work_reg  [RESOURCES];
    logic [CUSTOMERS-1:0]  done_reg;
    status_t               out_status_reg;
    logic [AMT_BITS-1:0]   out_avail_reg [MAX_RES];

    logic [COUNT_BITS-1:0] claim     [CUSTOMERS][RESOURCES];
    logic [COUNT_BITS-1:0] need      [CUSTOMERS][RESOURCES];
    logic [COUNT_BITS-1:0] avail     [RESOURCES];
    logic [COUNT_BITS-1:0] alloc_cur [RESOURCES];
    logic [COUNT_BITS-1:0] need_cur  [RESOURCES];
    logic [CW-1:0]         work_add  [RESOURCES];
    logic [CUSTOMERS-1:0]  fits;
    logic [CUSTOMERS-1:0]  pick;
    logic                  pick_any;
    logic                  all_done;
    logic                  cust_ok;
    logic                  over_need;
    logic                  over_avail;
    logic                  over_alloc;
    logic                  add_en;
    logic                  sub_en;

    // claims and need per customer; customers without a register claim zero
    always_comb
    begin
        for (int c = 0; c < CUSTOMERS; c++)
        begin
            for (int r = 0; r < RESOURCES; r++)
            begin
                if (c < CLAIM_REGS)
                    claim[c][r] = COUNT_BITS'(cfg_reg[CFG_CLAIM0 + c][8*r +: FW]);
                else
                    claim[c][r] = '0;
                need[c][r] = (claim[c][r] > alloc_reg[c][r]) ?
                             (claim[c][r] - alloc_reg[c][r]) : '0;
            end
        end
    end

    // available units, saturating at zero
    always_comb
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            if (CW'(cfg_reg[CFG_TOTAL][8*r +: FW]) > sum_reg[r])
                avail[r] = COUNT_BITS'(CW'(cfg_reg[CFG_TOTAL][8*r +: FW]) - sum_reg[r]);
            else
                avail[r] = '0;
        end
    end

    // row of the addressed customer
    always_comb
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            alloc_cur[r] = '0;
            need_cur[r]  = '0;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                if (cust_reg == CUST_BITS'(c))
                begin
                    alloc_cur[r] = alloc_reg[c][r];
                    need_cur[r]  = need[c][r];
                end
            end
        end
    end

    // request / release checks, status to the controller
    always_comb
    begin
        cust_ok    = (cust_reg < CUST_BITS'(CUSTOMERS));
        over_need  = 1'b0;
        over_avail = 1'b0;
        over_alloc = 1'b0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            if (CW'(amt_reg[r]) > CW'(need_cur[r]))
                over_need = 1'b1;
            if (CW'(amt_reg[r]) > CW'(avail[r]))
                over_avail = 1'b1;
            if (CW'(amt_reg[r]) > CW'(alloc_cur[r]))
                over_alloc = 1'b1;
        end
        stat.is_release    = op_reg;
        stat.pick_found    = pick_any;
        stat.all_done_next = all_done;
        if (op_reg)
        begin
            stat.chk_pass = cust_ok && !over_alloc;
            stat.chk_code = ST_REL_BIG;
        end
        else if (!cust_ok || over_need)
        begin
            stat.chk_pass = 1'b0;
            stat.chk_code = ST_EXCEEDS;
        end
        else if (over_avail)
        begin
            stat.chk_pass = 1'b0;
            stat.chk_code = ST_INSUFF;
        end
        else
        begin
            stat.chk_pass = 1'b1;
            stat.chk_code = ST_GRANTED;
        end
    end

    // one safety round: lowest unfinished customer whose need fits the work
    always_comb
    begin
        for (int c = 0; c < CUSTOMERS; c++)
        begin
            fits[c] = !done_reg[c];
            for (int r = 0; r < RESOURCES; r++)
            begin
                if (CW'(need[c][r]) > work_reg[r])
                    fits[c] = 1'b0;
            end
        end
        pick = fits & (~fits + CUSTOMERS'(1));
        for (int r = 0; r < RESOURCES; r++)
        begin
            work_add[r] = '0;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                if (pick[c])
                    work_add[r] = work_add[r] | CW'(alloc_reg[c][r]);
            end
        end
        pick_any = |fits;
        all_done = &(done_reg | pick);
    end

    assign add_en = cmd.apply && !op_reg;
    assign sub_en = (cmd.apply && op_reg) || cmd.undo;

    // registers, table and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
                cfg_reg[i] <= '0;
            for (int c = 0; c < CUSTOMERS; c++)
                for (int r = 0; r < RESOURCES; r++)
                    alloc_reg[c][r] <= '0;
            for (int r = 0; r < RESOURCES; r++)
                sum_reg[r] <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index < CFG_IDX_BITS'(CFG_REGS)))
                cfg_reg[cfg_index] <= cfg_data;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                for (int r = 0; r < RESOURCES; r++)
                begin
                    if (cust_reg == CUST_BITS'(c))
                    begin
                        if (add_en)
                            alloc_reg[c][r] <= COUNT_BITS'(CW'(alloc_reg[c][r])
                                                           + CW'(amt_reg[r]));
                        else if (sub_en)
                            alloc_reg[c][r] <= COUNT_BITS'(CW'(alloc_reg[c][r])
                                                           - CW'(amt_reg[r]));
                    end
                end
            end
            for (int r = 0; r < RESOURCES; r++)
            begin
                if (add_en)
                    sum_reg[r] <= sum_reg[r] + CW'(amt_reg[r]);
                else if (sub_en)
                    sum_reg[r] <= sum_reg[r] - CW'(amt_reg[r]);
            end
        end
    end

    // input capture, work vector, output word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            cust_reg <= in_customer;
            for (int r = 0; r < RESOURCES; r++)
                amt_reg[r] <= in_amount[r];
        end
        if (add_en)
        begin
            done_reg <= '0;
            for (int r = 0; r < RESOURCES; r++)
                work_reg[r] <= CW'(avail[r]) - CW'(amt_reg[r]);
        end
        else if (cmd.step)
        begin
            done_reg <= done_reg | pick;
            for (int r = 0; r < RESOURCES; r++)
                work_reg[r] <= work_reg[r] + work_add[r];
        end
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_code;
            for (int r = 0; r < MAX_RES; r++)
            begin
                if (r < RESOURCES)
                    out_avail_reg[r] <= AMT_BITS'(avail[r]);
                else
                    out_avail_reg[r] <= '0;
            end
        end
    end

    assign out_status = out_status_reg;
    assign out_avail  = out_avail_reg;

endmodule

/* hw/rtl/banker_safe_resource_allocator_core.sv */
// ============================================================================
// banker_safe_resource_allocator_core: deadlock-avoiding resource allocator
// Grants a request only when it fits the customer's need and the available
// units and leaves the system in a safe state; checks releases.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   config  | cfg_we, cfg_index, cfg_data               | in
//   input   | in_valid/in_ready, op, customer, amount_* | in
//   output  | out_valid/out_ready, status, avail_*      | out
//
// A release or denied request goes from accept through the check and finish
// steps back to idle; a request that reaches the safety check runs 1..CUSTOMERS
// rounds (5 at most by default), one safety round per cycle, before finish.
// Reset clears registers, allocation table and sums at once.
// The output word sits in a register; a new word is accepted while it waits,
// and only the finish step stalls on out_ready.
// ============================================================================
module banker_safe_resource_allocator_core #(
    parameter int CUSTOMERS  = bsra_pkg::CUSTOMERS_DEF,
    parameter int RESOURCES  = bsra_pkg::RESOURCES_DEF,
    parameter int COUNT_BITS = bsra_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bsra_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [bsra_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [bsra_pkg::CUST_BITS-1:0]    customer,
    input  logic [bsra_pkg::AMT_BITS-1:0]     amount_r0,
    input  logic [bsra_pkg::AMT_BITS-1:0]     amount_r1,
    input  logic [bsra_pkg::AMT_BITS-1:0]     amount_r2,
    input  logic [bsra_pkg::AMT_BITS-1:0]     amount_r3,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    output logic [bsra_pkg::AMT_BITS-1:0]     avail_r0,
    output logic [bsra_pkg::AMT_BITS-1:0]     avail_r1,
    output logic [bsra_pkg::AMT_BITS-1:0]     avail_r2,
    output logic [bsra_pkg::AMT_BITS-1:0]     avail_r3
);
    import bsra_pkg::*;

    ctrl_cmd_t           cmd;
    dp_stat_t            stat;
    status_t             out_status;
    logic [AMT_BITS-1:0] amount [MAX_RES];
    logic [AMT_BITS-1:0] avail  [MAX_RES];

    assign amount[0] = amount_r0;
    assign amount[1] = amount_r1;
    assign amount[2] = amount_r2;
    assign amount[3] = amount_r3;

    // sequencer
    bsra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, checks, safety rounds
    bsra_datapath #(
        .CUSTOMERS  (CUSTOMERS),
        .RESOURCES  (RESOURCES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (op),
        .in_customer (customer),
        .in_amount   (amount),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (out_status),
        .out_avail   (avail)
    );

    assign status   = out_status;
    assign avail_r0 = avail[0];
    assign avail_r1 = avail[1];
    assign avail_r2 = avail[2];
    assign avail_r3 = avail[3];

endmodule
